### design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types for the double-ended queue
// Request codes, controller states and the command and status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int FUNC_W = 4;
    localparam int WORD_W = 64;

    // Head is the front of the queue, tail is the back.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_TAIL  = 4'd0,
        FUNC_PUSH_HEAD  = 4'd1,
        FUNC_POP_TAIL   = 4'd2,
        FUNC_POP_HEAD   = 4'd3,
        FUNC_PEEK_TAIL  = 4'd4,
        FUNC_PEEK_HEAD  = 4'd5,
        FUNC_READ_POS   = 4'd6,
        FUNC_WRITE_POS  = 4'd7,
        FUNC_CLEAR      = 4'd8
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_DELIVER
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture the incoming request
        logic exec;     // memory access and pointer/count update
        logic deliver;  // move the result into the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free; // output register empty or being drained this cycle
    } status_t;

endpackage

`default_nettype wire

### design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: request sequencer
// Steps each request through capture, memory access and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire deq_pkg::status_t status,
    output deq_pkg::cmd_t         cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = deq_pkg::ST_ACCESS;
                end
            end
            deq_pkg::ST_ACCESS:
            begin
                state_next = deq_pkg::ST_DELIVER;
            end
            deq_pkg::ST_DELIVER:
            begin
                if (status.out_free)
                begin
                    state_next = deq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.deliver = 1'b0;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            deq_pkg::ST_ACCESS:
            begin
                cmd.exec = 1'b1;
            end
            deq_pkg::ST_DELIVER:
            begin
                cmd.deliver = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath: ring memory, pointers and output register
// Holds the slot memory, the front pointer and element count, decodes the
// captured request and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath
#(
    parameter int DEPTH = 256,
    parameter int PTR_W = 8,
    parameter int CNT_W = 9,
    parameter int IN_W  = 80,
    parameter int OUT_W = 80
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  wire deq_pkg::cmd_t    cmd,
    output deq_pkg::status_t      status
);

    localparam int SUM_W  = PTR_W + 1;
    localparam int POS_LO = deq_pkg::FUNC_W + deq_pkg::WORD_W;

    // Captured request.
    deq_pkg::func_t              func_reg;
    logic [deq_pkg::WORD_W-1:0]  word_reg;
    logic [PTR_W-1:0]            pos_reg;

    // Queue state.
    logic [PTR_W-1:0]            front_reg;
    logic [PTR_W-1:0]            front_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;

    // Result of the access cycle.
    logic                        err_reg;
    logic                        rd_sel_reg;
    logic [deq_pkg::WORD_W-1:0]  rd_data_reg;

    // Output register.
    logic                        m_tvalid_reg;
    logic [deq_pkg::WORD_W-1:0]  out_word_reg;
    logic                        out_err_reg;
    logic [CNT_W-1:0]            out_count_reg;

    logic [deq_pkg::WORD_W-1:0]  mem [DEPTH];

    logic                        full;
    logic                        empty;
    logic                        pos_bad;
    logic [PTR_W-1:0]            offset;
    logic [SUM_W-1:0]            addr_sum;
    logic [PTR_W-1:0]            slot_addr;
    logic [PTR_W-1:0]            front_dec;
    logic [PTR_W-1:0]            front_inc;
    logic [PTR_W-1:0]            mem_addr;
    logic                        mem_we;
    logic                        mem_re;
    logic                        err;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_bad = (SUM_W'(pos_reg) >= SUM_W'(count_reg));

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : (front_reg - 1'b1);
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : (front_reg + 1'b1);

    // Element offset from the front: the free slot behind the tail for a
    // tail push, the requested position for indexed access, else the tail.
    always_comb
    begin
        case (func_reg)
            deq_pkg::FUNC_PUSH_TAIL:
            begin
                offset = PTR_W'(count_reg);
            end
            deq_pkg::FUNC_READ_POS,
            deq_pkg::FUNC_WRITE_POS:
            begin
                offset = pos_reg;
            end
            default:
            begin
                offset = PTR_W'(count_reg - CNT_W'(1));
            end
        endcase
    end

    // Front pointer plus an offset, wrapped once around the ring.
    assign addr_sum  = SUM_W'(front_reg) + SUM_W'(offset);
    assign slot_addr = (addr_sum >= SUM_W'(DEPTH)) ?
                       PTR_W'(addr_sum - SUM_W'(DEPTH)) : PTR_W'(addr_sum);

    always_comb
    begin
        mem_addr   = slot_addr;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        err        = 1'b0;
        front_next = front_reg;
        count_next = count_reg;
        case (func_reg)
            deq_pkg::FUNC_PUSH_TAIL:
            begin
                err    = full;
                mem_we = !full;
                if (!full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::FUNC_PUSH_HEAD:
            begin
                mem_addr = front_dec;
                err      = full;
                mem_we   = !full;
                if (!full)
                begin
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::FUNC_POP_TAIL,
            deq_pkg::FUNC_PEEK_TAIL:
            begin
                err    = empty;
                mem_re = !empty;
                if (!empty && func_reg == deq_pkg::FUNC_POP_TAIL)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::FUNC_POP_HEAD,
            deq_pkg::FUNC_PEEK_HEAD:
            begin
                mem_addr = front_reg;
                err      = empty;
                mem_re   = !empty;
                if (!empty && func_reg == deq_pkg::FUNC_POP_HEAD)
                begin
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::FUNC_READ_POS:
            begin
                err    = pos_bad;
                mem_re = !pos_bad;
            end
            deq_pkg::FUNC_WRITE_POS:
            begin
                err    = pos_bad;
                mem_we = !pos_bad;
            end
            deq_pkg::FUNC_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                err = 1'b0;
            end
        endcase
    end

    // Request capture and access results; payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= deq_pkg::func_t'(s_tdata[deq_pkg::FUNC_W-1:0]);
            word_reg <= s_tdata[POS_LO-1:deq_pkg::FUNC_W];
            pos_reg  <= s_tdata[POS_LO+PTR_W-1:POS_LO];
        end
        if (cmd.exec)
        begin
            err_reg    <= err;
            rd_sel_reg <= mem_re;
        end
        if (cmd.deliver)
        begin
            out_word_reg  <= rd_sel_reg ? rd_data_reg : '0;
            out_err_reg   <= err_reg;
            out_count_reg <= count_reg;
        end
    end

    // Slot memory: one port, read data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[mem_addr] <= word_reg;
        end
        if (cmd.exec && mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (cmd.deliver)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({(out_count_reg == '0), out_count_reg, out_err_reg,
                              out_word_reg});

endmodule

`default_nettype wire

### design/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of 64-bit words
// Ring-buffer deque answering one result per request on stream channels.
// ----------------------------------------------------------------------------
// Each request on the slave channel pushes, pops or peeks at either end, reads
// or writes the element at a position counted from the front, or clears the
// queue, and produces exactly one result on the master channel carrying the
// word concerned (zero unless popped, peeked or read), an error flag, the
// element count after the request and an empty flag. A refused request (pop
// or peek on an empty queue, push on a full queue, position at or beyond the
// count) raises the error flag and changes nothing. A request is captured,
// then makes the single access to the slot memory together with the
// pointer and count update, then moves its result into the output register
// once that register is free. The next request is accepted while the
// previous result still waits in that register, but not before the result
// has reached it. The slot memory is not cleared after reset; the queue is
// usable right away.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top
#(
    parameter int DEPTH = 256
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    // Request channel.
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0 up: func (4), data_word (64), position
    // (clog2(DEPTH)), zero padding to whole bytes.
    input  wire logic [((deq_pkg::FUNC_W + deq_pkg::WORD_W + $clog2(DEPTH) + 7) / 8) * 8 - 1:0]
                                  s_tdata,

    // Result channel.
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // Fields from bit 0 up: result_word (64), error (1), element_count
    // (clog2(DEPTH + 1)), is_empty (1), zero padding to whole bytes.
    output logic [((deq_pkg::WORD_W + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8 - 1:0]
                                  m_tdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IN_W  = ((deq_pkg::FUNC_W + deq_pkg::WORD_W + PTR_W + 7) / 8) * 8;
    localparam int OUT_W = ((deq_pkg::WORD_W + CNT_W + 2 + 7) / 8) * 8;

    // Bit positions of the result fields, used by the checks below.
    localparam int ERR_BIT   = deq_pkg::WORD_W;
    localparam int CNT_LO    = deq_pkg::WORD_W + 1;
    localparam int EMPTY_BIT = CNT_LO + CNT_W;

    deq_pkg::cmd_t    cmd;
    deq_pkg::status_t status;

    // The controller only sequences; every piece of queue state lives in
    // the datapath.
    deq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    deq_datapath
    #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W),
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef SYNTHESIS
    // Only one request is in flight: after acceptance the channel closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another was in flight");

    // The reported count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[EMPTY_BIT-1:CNT_LO] <= CNT_W'(DEPTH)))
        else $error("element count beyond capacity");

    // The empty flag agrees with the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[EMPTY_BIT] == (m_tdata[EMPTY_BIT-1:CNT_LO] == '0)))
        else $error("empty flag disagrees with count");

    // A refused request never returns a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[ERR_BIT]) |-> (m_tdata[deq_pkg::WORD_W-1:0] == '0))
        else $error("error result carries a nonzero word");
`endif

endmodule

`default_nettype wire

### sim/tb_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top: self-checking bench for the double-ended queue
// A queue of requests feeds a clocked stream driver. A shadow deque predicts
// the answer to every accepted request, and a clocked monitor compares each
// returned answer field by field. The run has three phases that change how
// often each side of the stream stalls; the first opens with directed requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_double_ended_queue_top;

    localparam int FUNC_W    = deq_pkg::FUNC_W;
    localparam int WORD_W    = deq_pkg::WORD_W;
    localparam int DEPTH     = 256;
    localparam int POS_W     = $clog2(DEPTH);
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int S_TDATA_W = ((FUNC_W + WORD_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + COUNT_W + 2 + 7) / 8) * 8;

    // Codes above clear are decoded as no operation by the block.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

    // Cycles without any handshake while work is outstanding before giving up.
    localparam int STALL_LIMIT = 2000;
    // Cycles to watch the result channel after the last answer has arrived.
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
    } request_t;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic               refused;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } answer_t;

    typedef enum {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } segment_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    double_ended_queue_top #(
        .DEPTH (DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Requests waiting to be offered; the head is the one on the bus while
    // s_tvalid is high. Answers predicted for accepted requests, oldest first.
    request_t pending_requests[$];
    answer_t  awaited_answers[$];

    // Stall rates in percent, changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Shadow copy of the deque state.
    logic [WORD_W-1:0] shadow_slots[DEPTH];
    int shadow_front = 0;
    int shadow_count = 0;

    // Element count as the stimulus generator tracks it. The count depends
    // only on the sequence of operations, so it is exact at generation time.
    int plan_count = 0;

    int mismatch_count = 0;
    int answers_checked = 0;
    int requests_applied = 0;
    int refused_requests = 0;
    int full_refusals = 0;
    int peak_count = 0;
    int stall_cycles = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Apply one accepted request to the shadow deque and return its answer.
    function automatic answer_t apply_request(request_t rq);
        answer_t ans;
        int      slot;
        ans.word = '0;
        ans.refused = 1'b0;
        case (rq.op)
            deq_pkg::FUNC_PUSH_TAIL:
            begin
                if (shadow_count >= DEPTH)
                begin
                    ans.refused = 1'b1;
                    full_refusals++;
                end
                else
                begin
                    slot = (shadow_front + shadow_count) % DEPTH;
                    shadow_slots[slot] = rq.word;
                    shadow_count++;
                end
            end
            deq_pkg::FUNC_PUSH_HEAD:
            begin
                if (shadow_count >= DEPTH)
                begin
                    ans.refused = 1'b1;
                    full_refusals++;
                end
                else
                begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_front] = rq.word;
                    shadow_count++;
                end
            end
            deq_pkg::FUNC_POP_TAIL, deq_pkg::FUNC_PEEK_TAIL:
            begin
                if (shadow_count == 0)
                    ans.refused = 1'b1;
                else
                begin
                    ans.word = shadow_slots[(shadow_front + shadow_count - 1) % DEPTH];
                    if (rq.op == deq_pkg::FUNC_POP_TAIL)
                        shadow_count--;
                end
            end
            deq_pkg::FUNC_POP_HEAD, deq_pkg::FUNC_PEEK_HEAD:
            begin
                if (shadow_count == 0)
                    ans.refused = 1'b1;
                else
                begin
                    ans.word = shadow_slots[shadow_front];
                    if (rq.op == deq_pkg::FUNC_POP_HEAD)
                    begin
                        shadow_front = (shadow_front + 1) % DEPTH;
                        shadow_count--;
                    end
                end
            end
            deq_pkg::FUNC_READ_POS:
            begin
                if (int'(rq.pos) >= shadow_count)
                    ans.refused = 1'b1;
                else
                    ans.word = shadow_slots[(shadow_front + int'(rq.pos)) % DEPTH];
            end
            deq_pkg::FUNC_WRITE_POS:
            begin
                if (int'(rq.pos) >= shadow_count)
                    ans.refused = 1'b1;
                else
                    shadow_slots[(shadow_front + int'(rq.pos)) % DEPTH] = rq.word;
            end
            deq_pkg::FUNC_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        ans.count = shadow_count[COUNT_W-1:0];
        ans.empty = (shadow_count == 0);
        requests_applied++;
        if (ans.refused)
            refused_requests++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        return ans;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(request_t rq);
        logic [S_TDATA_W-1:0] bits;
        bits = '0;
        bits[0 +: FUNC_W] = rq.op;
        bits[FUNC_W +: WORD_W] = rq.word;
        bits[FUNC_W + WORD_W +: POS_W] = rq.pos;
        return bits;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic add_request(input logic [FUNC_W-1:0] op,
                               input logic [WORD_W-1:0] word,
                               input logic [POS_W-1:0] pos);
        request_t rq;
        rq.op = op;
        rq.word = word;
        rq.pos = pos;
        pending_requests.insert(pending_requests.size(), rq);
        case (op)
            deq_pkg::FUNC_PUSH_TAIL, deq_pkg::FUNC_PUSH_HEAD:
                if (plan_count < DEPTH)
                    plan_count++;
            deq_pkg::FUNC_POP_TAIL, deq_pkg::FUNC_POP_HEAD:
                if (plan_count > 0)
                    plan_count--;
            deq_pkg::FUNC_CLEAR:
                plan_count = 0;
            default:
                ;
        endcase
    endtask

    // Mostly random patterns, with the all-zero and all-one words mixed in.
    function automatic logic [WORD_W-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly a valid position for the current count, otherwise anything.
    function automatic logic [POS_W-1:0] random_pos();
        if (plan_count > 0 && $urandom_range(0, 99) < 75)
            return POS_W'($urandom_range(0, plan_count - 1));
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic logic [FUNC_W-1:0] random_access_op();
        case ($urandom_range(0, 3))
            0: return deq_pkg::FUNC_PEEK_TAIL;
            1: return deq_pkg::FUNC_PEEK_HEAD;
            2: return deq_pkg::FUNC_READ_POS;
            default: return deq_pkg::FUNC_WRITE_POS;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op(segment_kind_t kind);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        case (kind)
            SEG_FILL:
                if (roll < 72)
                    return $urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_HEAD
                                                : deq_pkg::FUNC_PUSH_TAIL;
                else
                    return random_access_op();
            SEG_DRAIN:
                if (roll < 72)
                    return $urandom_range(0, 1) ? deq_pkg::FUNC_POP_HEAD
                                                : deq_pkg::FUNC_POP_TAIL;
                else
                    return random_access_op();
            default:
                if (roll < 4)
                    return deq_pkg::FUNC_CLEAR;
                else
                    return FUNC_W'($urandom_range(deq_pkg::FUNC_PUSH_TAIL,
                                                  deq_pkg::FUNC_WRITE_POS));
        endcase
    endfunction

    // Random segments that push the count up, pull it down or wander, so the
    // queue visits empty, full and everything in between.
    task automatic add_random_block(input int total);
        segment_kind_t kind;
        int            seg_len;
        int            added;
        added = 0;
        while (added < total)
        begin
            if (plan_count < 32 && $urandom_range(0, 99) < 60)
                kind = SEG_FILL;
            else if (plan_count > DEPTH - 32 && $urandom_range(0, 99) < 60)
                kind = SEG_DRAIN;
            else
                kind = segment_kind_t'($urandom_range(0, 2));
            seg_len = $urandom_range(16, 120);
            for (int i = 0; i < seg_len && added < total; i++)
            begin
                add_request(pick_op(kind), random_word(), random_pos());
                added++;
            end
        end
    endtask

    task automatic wait_until_quiet();
        while (pending_requests.size() != 0 || awaited_answers.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: holds a request until accepted, otherwise offers the
    // next one unless it decides to idle this cycle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        logic     holding;
        request_t taken;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            holding = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
            begin
                taken = pending_requests[0];
                pending_requests.delete(0);
                awaited_answers.insert(awaited_answers.size(), apply_request(taken));
            end
            if (!holding)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pack_request(pending_requests[0]);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Answer monitor: checks every accepted answer against the oldest
    // prediction and throttles m_tready at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : answer_monitor
        answer_t want;
        answer_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.word = m_tdata[0 +: WORD_W];
                got.refused = m_tdata[WORD_W];
                got.count = m_tdata[WORD_W + 1 +: COUNT_W];
                got.empty = m_tdata[WORD_W + 1 + COUNT_W];
                if (awaited_answers.size() == 0)
                    report_mismatch("answer arrived with no request outstanding");
                else
                begin
                    want = awaited_answers[0];
                    awaited_answers.delete(0);
                    if (got.word !== want.word)
                        report_mismatch($sformatf("answer %0d: word %h, expected %h",
                                                  answers_checked, got.word, want.word));
                    if (got.refused !== want.refused)
                        report_mismatch($sformatf("answer %0d: error flag %b, expected %b",
                                                  answers_checked, got.refused, want.refused));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("answer %0d: count %0d, expected %0d",
                                                  answers_checked, got.count, want.count));
                    if (got.empty !== want.empty)
                        report_mismatch($sformatf("answer %0d: empty flag %b, expected %b",
                                                  answers_checked, got.empty, want.empty));
                end
                answers_checked++;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: gives up when work is outstanding but nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (pending_requests.size() == 0 && awaited_answers.size() == 0))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d answers outstanding",
                         STALL_LIMIT, awaited_answers.size());
                $display("tb_double_ended_queue_top failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Phase one: sender rarely idles, receiver stalls most of the time.
        send_idle_pct = 7;
        recv_idle_pct = 61;

        // Directed opening. Everything on an empty queue is refused first.
        add_request(deq_pkg::FUNC_POP_TAIL, '0, '0);
        add_request(deq_pkg::FUNC_POP_HEAD, '0, '0);
        add_request(deq_pkg::FUNC_PEEK_TAIL, '0, '0);
        add_request(deq_pkg::FUNC_PEEK_HEAD, '0, '0);
        add_request(deq_pkg::FUNC_READ_POS, '0, '0);
        add_request(deq_pkg::FUNC_WRITE_POS, '1, '0);
        // Extreme words at the tail; pushing at the front wraps the pointer.
        add_request(deq_pkg::FUNC_PUSH_TAIL, '0, '1);
        add_request(deq_pkg::FUNC_PUSH_TAIL, '1, '0);
        add_request(deq_pkg::FUNC_PUSH_HEAD, 64'hA5A5_5A5A_0F0F_F0F0, '0);
        add_request(deq_pkg::FUNC_PEEK_HEAD, '0, '0);
        add_request(deq_pkg::FUNC_PEEK_TAIL, '0, '0);
        add_request(deq_pkg::FUNC_READ_POS, '0, 8'd1);
        add_request(deq_pkg::FUNC_READ_POS, '0, '1);
        add_request(deq_pkg::FUNC_WRITE_POS, 64'h0123_4567_89AB_CDEF, 8'd2);
        add_request(deq_pkg::FUNC_READ_POS, '0, 8'd2);
        // Position equal to the count is just out of range.
        add_request(deq_pkg::FUNC_WRITE_POS, '1, 8'd3);
        add_request(FUNC_UNUSED_LO, '1, '1);
        add_request(FUNC_UNUSED_HI, '1, '1);
        add_request(deq_pkg::FUNC_POP_HEAD, '0, '0);
        add_request(deq_pkg::FUNC_POP_TAIL, '0, '0);
        add_request(deq_pkg::FUNC_CLEAR, '0, '0);
        add_request(deq_pkg::FUNC_CLEAR, '0, '0);
        add_request(deq_pkg::FUNC_PUSH_HEAD, random_word(), '0);
        add_request(deq_pkg::FUNC_POP_TAIL, '0, '0);

        // Fill the queue past full so pushes get refused, then touch the
        // last position while every slot holds an element.
        for (int i = 0; i < DEPTH + 6; i++)
            add_request($urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_HEAD
                                             : deq_pkg::FUNC_PUSH_TAIL,
                        random_word(), random_pos());
        add_request(deq_pkg::FUNC_READ_POS, '0, '1);
        add_request(deq_pkg::FUNC_WRITE_POS, random_word(), '1);
        add_request(deq_pkg::FUNC_READ_POS, '0, '1);
        add_request(deq_pkg::FUNC_READ_POS, '0, '0);
        add_random_block(150);
        wait_until_quiet();

        // Phase two: the sender idles often and the receiver rarely.
        send_idle_pct = 61;
        recv_idle_pct = 7;
        add_random_block(460);
        wait_until_quiet();

        // Phase three: both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_block(460);
        wait_until_quiet();

        // Any answer showing up now has no request behind it.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (awaited_answers.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", awaited_answers.size()));

        $display("Run covered %0d requests, %0d refused (%0d pushes on a full queue),",
                 requests_applied, refused_requests, full_refusals);
        $display("peak count %0d of %0d; answers checked: %0d, mismatches: %0d.",
                 peak_count, DEPTH, answers_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_double_ended_queue_top passed");
        else
            $display("tb_double_ended_queue_top failed");
        $finish;
    end

endmodule

### double_ended_queue_top.f
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_datapath.sv
design/double_ended_queue_top.sv
sim/tb_double_ended_queue_top.sv
